>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/gcns_pkg.sv
package gcns_pkg;

	// result status codes
	localparam logic [2:0] ST_NEIGHBOR  = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_DROPPED   = 3'd2;
	localparam logic [2:0] ST_TRUNCATED = 3'd3;
	localparam logic [2:0] ST_BAD_QUERY = 3'd4;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_GRID_SIDE = 2'd0;
	localparam logic [1:0] CFG_INV_CELL  = 2'd1;
	localparam logic [1:0] CFG_LIMIT     = 2'd2;

	// register reset values
	localparam logic [4:0]  GRID_SIDE_RST = 5'd16;
	localparam logic [12:0] INV_CELL_RST  = 13'd4096;
	localparam logic [10:0] LIMIT_RST     = 11'd1024;

	// request to the shared binning multiplier
	typedef struct packed {
		logic        start;
		logic [15:0] pos;
		logic [12:0] inv;
	} bin_req_t;

endpackage

>>> rtl/gcns_ram.sv
module gcns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/gcns_bin.sv
module gcns_bin import gcns_pkg::*; #(
	parameter int CW = 4
) (
	input  logic          clk,
	input  bin_req_t      req,
	input  logic [CW-1:0] side_m1,
	output logic [CW-1:0] coord
);

	logic [28:0] prod_q;
	logic [5:0]  raw;

	// q0.16 times q5.8, registered
	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_q <= 29'(req.pos) * 29'(req.inv);
		end
	end

	// integer part, clamped to the last cell
	assign raw   = {1'b0, prod_q[28:24]};
	assign coord = (raw > 6'(side_m1)) ? side_m1 : raw[CW-1:0];

endmodule

>>> rtl/grid_cell_neighbor_search.sv
// Uniform grid cell list over the unit cube, 3-D.
// Input channel in_valid/in_stall: operation 0 inserts a q0.16 position
// (first starts a new frame), operation 1 asks for the neighbors of a particle.
// Output channel out_valid/out_stall: status, neighbor_index, last; one result
// per insert, zero to MAX_LIST results per query, last set on the final one.
// Config channel cfg_valid/cfg_ready (always ready): 0 grid side,
// 1 inverse cell size, 2 particle limit; write only while idle.
// An insert checks the particle limit and, below it, makes three passes through
// the shared multiplier, then a fill read and the bucket write.
// A query reads the fill count of each cell in the window and each entry found,
// one at a time through the one read port of the fill and slot memories.
// An insert with first set sweeps the fill memory, one cell a cycle, before
// binning. After reset the same sweep runs; in_stall stays high until it ends.
// A stalled receiver holds the output register, and the walk waits on it.
`include "assert_macros.svh"

module grid_cell_neighbor_search import gcns_pkg::*; #(
	parameter int MAX_GRID_SIDE = 16,
	parameter int MAX_PARTICLES = 1024,
	parameter int CELL_CAPACITY = 8,
	parameter int MAX_LIST      = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic        first,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [15:0] pos_z,
	input  logic [9:0]  query_particle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [9:0]  neighbor_index,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int CW    = MAX_GRID_SIDE > 1 ? $clog2(MAX_GRID_SIDE) : 1;
	localparam int AW    = 3 * CW;
	localparam int NCELL = 1 << AW;
	localparam int SW    = CELL_CAPACITY > 1 ? $clog2(CELL_CAPACITY) : 1;
	localparam int FW    = $clog2(CELL_CAPACITY + 1);
	localparam int PW    = MAX_PARTICLES > 1 ? $clog2(MAX_PARTICLES) : 1;
	localparam int LW    = $clog2(MAX_PARTICLES + 1);
	localparam int EW    = MAX_LIST > 1 ? $clog2(MAX_LIST) : 1;

	localparam logic [3:0] S_CLR     = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_INS_CHK = 4'd2;
	localparam logic [3:0] S_BIN_M   = 4'd3;
	localparam logic [3:0] S_BIN_W   = 4'd4;
	localparam logic [3:0] S_FILL_RD = 4'd5;
	localparam logic [3:0] S_FILL_WT = 4'd6;
	localparam logic [3:0] S_EMIT1   = 4'd7;
	localparam logic [3:0] S_PC_RD   = 4'd8;
	localparam logic [3:0] S_PC_WT   = 4'd9;
	localparam logic [3:0] S_CELL_RD = 4'd10;
	localparam logic [3:0] S_CELL_WT = 4'd11;
	localparam logic [3:0] S_SLOT_RD = 4'd12;
	localparam logic [3:0] S_SLOT_WT = 4'd13;
	localparam logic [3:0] S_END     = 4'd14;

	logic [3:0]    state_q;
	logic [4:0]    grid_side_q;
	logic [12:0]   inv_cell_q;
	logic [10:0]   limit_q;
	logic [LW-1:0] loaded_q;
	logic [AW-1:0] clr_q;
	logic          clr_frame_q;

	logic          op_q;
	logic [15:0]   px_q, py_q, pz_q;
	logic [9:0]    qp_q;
	logic [1:0]    ax_q;
	logic [CW-1:0] cx_q, cy_q, cz_q;

	logic [CW-1:0] lo_q [3];
	logic [CW-1:0] hi_q [3];
	logic [CW-1:0] wx_q, wy_q, wz_q;
	logic [FW-1:0] fill_n_q;
	logic [SW-1:0] slot_q;
	logic [PW-1:0] pend_q;
	logic          pend_v_q;
	logic [EW-1:0] emitted_q;

	logic [2:0]    res_status_q;
	logic [PW-1:0] res_idx_q;

	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [PW-1:0] nidx_q;
	logic          last_q;

	// effective grid side minus one and particle limit
	logic [5:0]    side_eff;
	logic [CW-1:0] side_m1;
	logic [31:0]   limit_eff;

	always_comb begin
		if (grid_side_q == 5'd0) begin
			side_eff = 6'd1;
		end else if (32'(grid_side_q) > MAX_GRID_SIDE) begin
			side_eff = 6'(MAX_GRID_SIDE);
		end else begin
			side_eff = {1'b0, grid_side_q};
		end
		if (limit_q == 11'd0) begin
			limit_eff = 32'd1;
		end else if (32'(limit_q) > MAX_PARTICLES) begin
			limit_eff = 32'(MAX_PARTICLES);
		end else begin
			limit_eff = 32'(limit_q);
		end
	end

	assign side_m1 = CW'(side_eff - 6'd1);

	// shared binning multiplier
	bin_req_t      bin_req;
	logic [CW-1:0] bin_coord;

	always_comb begin
		bin_req.start = (state_q == S_BIN_M);
		bin_req.inv   = inv_cell_q;
		case (ax_q)
			2'd0:    bin_req.pos = px_q;
			2'd1:    bin_req.pos = py_q;
			default: bin_req.pos = pz_q;
		endcase
	end

	gcns_bin #(.CW(CW)) u_bin (
		.clk     (clk),
		.req     (bin_req),
		.side_m1 (side_m1),
		.coord   (bin_coord)
	);

	// memories
	logic [AW-1:0]    ins_cell, walk_cell;
	logic             fill_we, slot_we, pc_we;
	logic [AW-1:0]    fill_waddr, fill_raddr;
	logic [FW-1:0]    fill_wdata, fill_rdata;
	logic [PW-1:0]    slot_rdata;
	logic [AW-1:0]    pc_rdata;
	logic [PW-1:0]    qp_addr;
	logic [31:0]      qp_wide;
	logic             fill_has_room;

	assign ins_cell      = {cz_q, cy_q, cx_q};
	assign walk_cell     = {wz_q, wy_q, wx_q};
	assign fill_raddr    = (op_q == OP_QUERY) ? walk_cell : ins_cell;
	assign fill_has_room = 32'(fill_rdata) < CELL_CAPACITY;
	assign qp_wide       = 32'(qp_q);
	assign qp_addr       = qp_wide[PW-1:0];

	always_comb begin
		fill_we    = 1'b0;
		fill_waddr = ins_cell;
		fill_wdata = FW'(fill_rdata + FW'(1));
		slot_we    = 1'b0;
		pc_we      = 1'b0;
		if (state_q == S_CLR) begin
			fill_we    = 1'b1;
			fill_waddr = clr_q;
			fill_wdata = '0;
		end else if (state_q == S_FILL_WT) begin
			pc_we   = 1'b1;
			fill_we = fill_has_room;
			slot_we = fill_has_room;
		end
	end

	gcns_ram #(.WIDTH(FW), .DEPTH(NCELL)) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	gcns_ram #(.WIDTH(PW), .DEPTH(NCELL << SW)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr ({ins_cell, fill_rdata[SW-1:0]}),
		.wdata (loaded_q[PW-1:0]),
		.raddr ({walk_cell, slot_q}),
		.rdata (slot_rdata)
	);

	gcns_ram #(.WIDTH(AW), .DEPTH(MAX_PARTICLES)) u_pcell_ram (
		.clk   (clk),
		.we    (pc_we),
		.waddr (loaded_q[PW-1:0]),
		.wdata (ins_cell),
		.raddr (qp_addr),
		.rdata (pc_rdata)
	);

	// window bounds of the queried cell
	logic [CW-1:0] qc [3];
	logic [CW-1:0] lo_n [3];
	logic [CW-1:0] hi_n [3];
	logic          win_empty;

	assign qc[0] = pc_rdata[CW-1:0];
	assign qc[1] = pc_rdata[2*CW-1:CW];
	assign qc[2] = pc_rdata[3*CW-1:2*CW];

	always_comb begin
		win_empty = 1'b0;
		for (int d = 0; d < 3; d++) begin
			lo_n[d] = (qc[d] == '0) ? '0 : CW'(qc[d] - CW'(1));
			if (({1'b0, qc[d]} + (CW+1)'(1)) > (CW+1)'(side_m1)) begin
				hi_n[d] = side_m1;
			end else begin
				hi_n[d] = CW'(qc[d] + CW'(1));
			end
			if (lo_n[d] > hi_n[d]) begin
				win_empty = 1'b1;
			end
		end
	end

	// next cell of the walk, z innermost
	logic walk_done;
	logic slot_last;

	assign walk_done = (wz_q == hi_q[2]) && (wy_q == hi_q[1]) && (wx_q == hi_q[0]);
	assign slot_last = ((FW+1)'(slot_q) + (FW+1)'(1)) == (FW+1)'(fill_n_q);

	// result selection
	logic          out_free;
	logic          emit;
	logic [2:0]    emit_status;
	logic [PW-1:0] emit_idx;
	logic          emit_last;
	logic          trunc_hit;

	assign out_free  = !out_valid_q || !out_stall;
	assign trunc_hit = 32'(emitted_q) == (MAX_LIST - 1);

	always_comb begin
		emit        = 1'b0;
		emit_status = ST_NEIGHBOR;
		emit_idx    = pend_q;
		emit_last   = 1'b0;
		unique case (state_q)
			S_EMIT1: begin
				emit        = out_free;
				emit_status = res_status_q;
				emit_idx    = res_idx_q;
				emit_last   = 1'b1;
			end
			S_SLOT_WT: begin
				emit = pend_v_q && out_free;
				if (trunc_hit) begin
					emit_status = ST_TRUNCATED;
					emit_idx    = '0;
					emit_last   = 1'b1;
				end
			end
			S_END: begin
				emit      = pend_v_q && out_free;
				emit_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= GRID_SIDE_RST;
			inv_cell_q  <= INV_CELL_RST;
			limit_q     <= LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GRID_SIDE: grid_side_q <= cfg_data[4:0];
				CFG_INV_CELL:  inv_cell_q  <= cfg_data;
				CFG_LIMIT:     limit_q     <= cfg_data[10:0];
				default:       grid_side_q <= grid_side_q;
			endcase
		end
	end

	// sequencer
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			loaded_q    <= '0;
			clr_q       <= '0;
			clr_frame_q <= 1'b0;
			pend_v_q    <= 1'b0;
			emitted_q   <= '0;
			ax_q        <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= AW'(clr_q + AW'(1));
					if (32'(clr_q) == NCELL - 1) begin
						state_q <= clr_frame_q ? S_INS_CHK : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q      <= operation;
						px_q      <= pos_x;
						py_q      <= pos_y;
						pz_q      <= pos_z;
						qp_q      <= query_particle;
						pend_v_q  <= 1'b0;
						emitted_q <= '0;
						if (operation == OP_INSERT) begin
							if (first) begin
								loaded_q    <= '0;
								clr_q       <= '0;
								clr_frame_q <= 1'b1;
								state_q     <= S_CLR;
							end else begin
								state_q <= S_INS_CHK;
							end
						end else if (32'(query_particle) >= 32'(loaded_q)) begin
							res_status_q <= ST_BAD_QUERY;
							res_idx_q    <= '0;
							state_q      <= S_EMIT1;
						end else begin
							state_q <= S_PC_RD;
						end
					end
				end
				S_INS_CHK: begin
					if (32'(loaded_q) >= limit_eff) begin
						res_status_q <= ST_DROPPED;
						res_idx_q    <= '0;
						state_q      <= S_EMIT1;
					end else begin
						ax_q    <= '0;
						state_q <= S_BIN_M;
					end
				end
				S_BIN_M: begin
					state_q <= S_BIN_W;
				end
				S_BIN_W: begin
					case (ax_q)
						2'd0:    cx_q <= bin_coord;
						2'd1:    cy_q <= bin_coord;
						default: cz_q <= bin_coord;
					endcase
					if (ax_q == 2'd2) begin
						state_q <= S_FILL_RD;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_BIN_M;
					end
				end
				S_FILL_RD: begin
					state_q <= S_FILL_WT;
				end
				S_FILL_WT: begin
					loaded_q     <= LW'(loaded_q + LW'(1));
					res_idx_q    <= loaded_q[PW-1:0];
					res_status_q <= fill_has_room ? ST_INSERTED : ST_DROPPED;
					state_q      <= S_EMIT1;
				end
				S_EMIT1: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_PC_RD: begin
					state_q <= S_PC_WT;
				end
				S_PC_WT: begin
					for (int d = 0; d < 3; d++) begin
						lo_q[d] <= lo_n[d];
						hi_q[d] <= hi_n[d];
					end
					wx_q    <= lo_n[0];
					wy_q    <= lo_n[1];
					wz_q    <= lo_n[2];
					state_q <= win_empty ? S_END : S_CELL_RD;
				end
				S_CELL_RD: begin
					state_q <= S_CELL_WT;
				end
				S_CELL_WT: begin
					fill_n_q <= fill_rdata;
					slot_q   <= '0;
					if (fill_rdata != '0) begin
						state_q <= S_SLOT_RD;
					end else if (walk_done) begin
						state_q <= S_END;
					end else begin
						state_q <= S_CELL_RD;
						if (wz_q != hi_q[2]) begin
							wz_q <= CW'(wz_q + CW'(1));
						end else begin
							wz_q <= lo_q[2];
							if (wy_q != hi_q[1]) begin
								wy_q <= CW'(wy_q + CW'(1));
							end else begin
								wy_q <= lo_q[1];
								wx_q <= CW'(wx_q + CW'(1));
							end
						end
					end
				end
				S_SLOT_RD: begin
					state_q <= S_SLOT_WT;
				end
				S_SLOT_WT: begin
					if (pend_v_q && !out_free) begin
						state_q <= S_SLOT_WT;
					end else if (pend_v_q && trunc_hit) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end else begin
						if (pend_v_q) begin
							emitted_q <= EW'(emitted_q + EW'(1));
						end
						pend_q   <= slot_rdata;
						pend_v_q <= 1'b1;
						if (!slot_last) begin
							slot_q  <= SW'(slot_q + SW'(1));
							state_q <= S_SLOT_RD;
						end else if (walk_done) begin
							state_q <= S_END;
						end else begin
							state_q <= S_CELL_RD;
							if (wz_q != hi_q[2]) begin
								wz_q <= CW'(wz_q + CW'(1));
							end else begin
								wz_q <= lo_q[2];
								if (wy_q != hi_q[1]) begin
									wy_q <= CW'(wy_q + CW'(1));
								end else begin
									wy_q <= lo_q[1];
									wx_q <= CW'(wx_q + CW'(1));
								end
							end
						end
					end
				end
				S_END: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= emit_status;
			nidx_q   <= emit_idx;
			last_q   <= emit_last;
		end
	end

	logic [31:0] nidx_wide;

	assign nidx_wide      = 32'(nidx_q);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign neighbor_index = nidx_wide[9:0];
	assign last           = last_q;

	// checks
	`ASSERT_ALWAYS(a_loaded_bound, clk, arst_n, 32'(loaded_q) <= MAX_PARTICLES)
	`ASSERT_IMPLIES(a_idle_no_pend, clk, arst_n, state_q == S_IDLE, !pend_v_q)
	`ASSERT_IMPLIES(a_fill_bound, clk, arst_n, fill_we, 32'(fill_wdata) <= CELL_CAPACITY)

endmodule
